// ===== rtl/gauss_jordan_linear_solver_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GAUSS_JORDAN_LINEAR_SOLVER_CORE_MACROS_SVH
`define GAUSS_JORDAN_LINEAR_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define GJLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gjls: property failed");

// next-cycle implication
`define GJLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gjls: property failed");

`endif

// ===== rtl/gjls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjls_pkg
// Shared types and constants of the Gauss-Jordan solver.
// ----------------------------------------------------------------------------
package gjls_pkg;

    localparam int VALUE_W     = 32;
    localparam int ORDER_W     = 4;
    localparam int STATUS_W    = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_UNIQUE   = 2'd0;
    localparam t_status ST_INFINITE = 2'd1;
    localparam t_status ST_NONE     = 2'd2;
    localparam t_status ST_OVERDEF  = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/gauss_jordan_linear_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_linear_solver_core
// Gauss-Jordan solver for an n x (n+1) augmented matrix in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - i_cfg_wr_en/i_cfg_wr_data set the order n (0 acts as 1, clamped to
//    MAX_ORDER) and restart loading; write only while idle.
//  - s_axis takes n*(n+1) coefficients row-major, one word per cycle.
//  - After the last word the block solves in place in the matrix RAM and then
//    sends n words on m_axis (value in tdata, status in tuser, tlast on the
//    final one), or a single status word when the answer is not unique.
//  - Solve time is set by the RAM sequencer and the bit-serial divider,
//    with pivot repair and output on top.
//  - s_axis_tready is low from the last coefficient until the final result
//    word is taken; a stalled m_axis holds its word and the block waits.
//  - Reset (synchronous, active low) returns to loading with order 4; the
//    RAM keeps no reset.
// ----------------------------------------------------------------------------
module gauss_jordan_linear_solver_core
    import gjls_pkg::*;
#(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [ORDER_W-1:0]        i_cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [VALUE_W-1:0]        s_axis_tdata,   // [31:0] coeff
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [VALUE_W-1:0]        m_axis_tdata,   // [31:0] value
    output logic [STATUS_W-1:0]       m_axis_tuser,   // [1:0] status
    output logic                      m_axis_tlast
);

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_ORDER + 1);

    typedef enum logic [4:0] {
        S_LOAD,
        S_FZ_RD, S_FZ_CHK,
        S_RP_RD0, S_RP_RD1, S_RP_CHK,
        S_SW_RD0, S_SW_RD1, S_SW_WR0, S_SW_WR1,
        S_EL_PIV, S_EL_PIVD, S_EL_ROW, S_EL_FDIV, S_EL_FWAIT,
        S_EL_RD0, S_EL_RD1, S_EL_MUL, S_EL_SCL, S_EL_WR, S_EL_ZERO,
        S_TR_RD, S_TR_CHK,
        S_NM_RD, S_NM_DIV, S_NM_WAIT,
        S_OUT_RD, S_OUT_SET, S_OUT_WAIT
    } t_state;

    function automatic logic [AW-1:0] f_addr(logic [IW-1:0] row, logic [IW-1:0] col,
                                             logic [IW-1:0] n);
        logic [2*IW+1:0] t;
        t = {{(IW+2){1'b0}}, row} * {{(IW+1){1'b0}}, n + IW'(1)}
            + {{(IW+2){1'b0}}, col};
        return t[AW-1:0];
    endfunction

    t_state                    r_state;
    logic [ORDER_W-1:0]        r_cfg;
    logic [AW-1:0]             r_load;
    logic [IW-1:0]             r_i;
    logic [IW-1:0]             r_c;
    logic [IW-1:0]             r_k;
    logic [IW-1:0]             r_att;
    logic                      r_after;
    logic                      r_nz;
    logic [IW:0]               r_zeros;
    logic signed [VALUE_W-1:0] r_tmp;
    logic signed [VALUE_W-1:0] r_piv;
    logic signed [VALUE_W-1:0] r_f;
    logic signed [VALUE_W-1:0] r_kc;
    logic signed [VALUE_W-1:0] r_rc;
    logic signed [2*VALUE_W-1:0] r_prod;
    logic signed [VALUE_W-1:0] r_scl;
    logic                      r_out_valid;
    logic [VALUE_W-1:0]        r_out_data;
    t_status                   r_out_st;
    logic                      r_out_last;

    logic [IW-1:0]             w_n;
    logic [IW-1:0]             w_n_m1;
    logic [AW:0]               w_total;
    logic                      w_in_acc;
    logic [IW-1:0]             w_rd_row, w_rd_col, w_wr_row, w_wr_col;
    logic [AW-1:0]             w_rd_addr, w_wr_addr;
    logic                      w_wr_en;
    logic [VALUE_W-1:0]        w_wr_data;
    logic signed [VALUE_W-1:0] w_rd_data;
    logic                      w_div_start;
    logic                      w_div_done;
    logic signed [VALUE_W-1:0] w_div_q;
    logic signed [2*VALUE_W-1:0] w_adj;
    logic signed [2*VALUE_W-1:0] w_shr;
    logic signed [VALUE_W:0]   w_sub;
    logic signed [VALUE_W-1:0] w_diff;
    logic                      w_zero;
    logic [IW:0]               w_zeros_new;

    always_comb begin
        if (r_cfg == '0) begin
            w_n = IW'(1);
        end else if ({{(IW+1){1'b0}}, r_cfg} > (IW+ORDER_W+1)'(MAX_ORDER)) begin
            w_n = IW'(MAX_ORDER);
        end else begin
            w_n = IW'(r_cfg);
        end
    end

    assign w_n_m1   = w_n - IW'(1);
    assign w_total  = (AW+1)'({{(AW+1){1'b0}}, w_n} * {{(AW+1){1'b0}}, w_n + IW'(1)});
    assign w_in_acc = s_axis_tvalid && (r_state == S_LOAD);

    always_comb begin
        w_rd_row = '0;
        w_rd_col = '0;
        unique case (r_state)
            S_FZ_RD:  begin w_rd_row = r_i; w_rd_col = r_i; end
            S_RP_RD0: begin w_rd_row = r_i; w_rd_col = r_k; end
            S_RP_RD1: begin w_rd_row = r_k; w_rd_col = r_i; end
            S_SW_RD0: begin w_rd_row = r_i; w_rd_col = r_c; end
            S_SW_RD1: begin w_rd_row = r_k; w_rd_col = r_c; end
            S_EL_PIV: begin w_rd_row = r_k; w_rd_col = r_k; end
            S_EL_ROW: begin w_rd_row = r_i; w_rd_col = r_k; end
            S_EL_RD0: begin w_rd_row = r_k; w_rd_col = r_c; end
            S_EL_RD1: begin w_rd_row = r_i; w_rd_col = r_c; end
            S_TR_RD:  begin w_rd_row = r_i; w_rd_col = r_c; end
            S_NM_RD:  begin w_rd_row = r_k; w_rd_col = r_c; end
            S_OUT_RD: begin w_rd_row = r_i; w_rd_col = w_n; end
            default:  begin w_rd_row = '0;  w_rd_col = '0;  end
        endcase
    end

    assign w_rd_addr = f_addr(w_rd_row, w_rd_col, w_n);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_row  = r_i;
        w_wr_col  = r_c;
        w_wr_data = w_rd_data;
        unique case (r_state)
            S_SW_WR0: w_wr_en = 1'b1;
            S_SW_WR1: begin
                w_wr_en   = 1'b1;
                w_wr_row  = r_k;
                w_wr_data = r_tmp;
            end
            S_EL_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_diff;
            end
            S_EL_ZERO: begin
                w_wr_en   = 1'b1;
                w_wr_col  = r_k;
                w_wr_data = '0;
            end
            S_NM_WAIT: begin
                w_wr_en   = w_div_done;
                w_wr_row  = r_k;
                w_wr_data = w_div_q;
            end
            default: w_wr_en = 1'b0;
        endcase
    end

    assign w_wr_addr = (r_state == S_LOAD) ? r_load : f_addr(w_wr_row, w_wr_col, w_n);

    gjls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en || w_in_acc),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ((r_state == S_LOAD) ? s_axis_tdata : w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_div_start = (r_state == S_EL_FDIV) || (r_state == S_NM_DIV);

    gjls_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_rd_data),
        .i_den   (r_piv),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // product scaled toward zero, then saturated
    assign w_adj = r_prod + (r_prod[2*VALUE_W-1] ?
                   (2*VALUE_W)'((64'd1 << FRAC_BITS) - 64'd1) : '0);
    assign w_shr = w_adj >>> FRAC_BITS;
    assign w_sub = {r_rc[VALUE_W-1], r_rc} - {r_scl[VALUE_W-1], r_scl};

    always_comb begin
        if (w_sub[VALUE_W] != w_sub[VALUE_W-1]) begin
            w_diff = w_sub[VALUE_W] ? VAL_MIN : VAL_MAX;
        end else begin
            w_diff = w_sub[VALUE_W-1:0];
        end
    end

    assign w_zero      = (w_rd_data == '0);
    assign w_zeros_new = r_zeros + {{IW{1'b0}}, w_zero};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cfg       <= ORDER_RESET;
            r_load      <= '0;
            r_i         <= '0;
            r_c         <= '0;
            r_k         <= '0;
            r_att       <= '0;
            r_after     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg  <= i_cfg_wr_data;
                r_load <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if ({1'b0, r_load} >= w_total - (AW+1)'(1)) begin
                            r_load  <= '0;
                            r_att   <= '0;
                            r_after <= 1'b0;
                            r_i     <= '0;
                            r_state <= S_FZ_RD;
                        end else begin
                            r_load <= r_load + AW'(1);
                        end
                    end
                end
                S_FZ_RD: r_state <= S_FZ_CHK;
                S_FZ_CHK: begin
                    if (w_zero || (r_i == w_n_m1)) begin
                        if (r_after) begin
                            r_att <= r_att + IW'(1);
                        end
                        if (r_after && (r_att + IW'(1) >= w_n)) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= '0;
                            r_out_st    <= ST_OVERDEF;
                            r_out_last  <= 1'b1;
                            r_state     <= S_OUT_WAIT;
                        end else if (!w_zero) begin
                            r_k     <= '0;
                            r_state <= S_EL_PIV;
                        end else begin
                            r_k     <= r_i;
                            r_i     <= '0;
                            r_after <= 1'b1;
                            r_state <= S_RP_RD0;
                        end
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_FZ_RD;
                    end
                end
                S_RP_RD0: r_state <= S_RP_RD1;
                S_RP_RD1: begin
                    r_nz    <= !w_zero;
                    r_state <= S_RP_CHK;
                end
                S_RP_CHK: begin
                    if (r_nz && !w_zero) begin
                        r_c     <= '0;
                        r_state <= S_SW_RD0;
                    end else if (r_i == w_n_m1) begin
                        r_i     <= '0;
                        r_state <= S_FZ_RD;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_RP_RD0;
                    end
                end
                S_SW_RD0: r_state <= S_SW_RD1;
                S_SW_RD1: begin
                    r_tmp   <= w_rd_data;
                    r_state <= S_SW_WR0;
                end
                S_SW_WR0: r_state <= S_SW_WR1;
                S_SW_WR1: begin
                    if (r_c == w_n) begin
                        r_i     <= '0;
                        r_state <= S_FZ_RD;
                    end else begin
                        r_c     <= r_c + IW'(1);
                        r_state <= S_SW_RD0;
                    end
                end
                S_EL_PIV: r_state <= S_EL_PIVD;
                S_EL_PIVD: begin
                    r_piv   <= w_rd_data;
                    r_i     <= '0;
                    r_state <= S_EL_ROW;
                end
                S_EL_ROW: begin
                    if (r_i == r_k) begin
                        if (r_i == w_n_m1) begin
                            r_i     <= '0;
                            r_c     <= '0;
                            r_zeros <= '0;
                            r_state <= S_TR_RD;
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end else begin
                        r_state <= S_EL_FDIV;
                    end
                end
                S_EL_FDIV: r_state <= S_EL_FWAIT;
                S_EL_FWAIT: begin
                    if (w_div_done) begin
                        r_f     <= w_div_q;
                        r_c     <= '0;
                        r_state <= S_EL_RD0;
                    end
                end
                S_EL_RD0: begin
                    if (r_c == r_k) begin
                        r_c <= r_c + IW'(1);
                    end else begin
                        r_state <= S_EL_RD1;
                    end
                end
                S_EL_RD1: begin
                    r_kc    <= w_rd_data;
                    r_state <= S_EL_MUL;
                end
                S_EL_MUL: begin
                    r_rc    <= w_rd_data;
                    r_prod  <= r_f * r_kc;
                    r_state <= S_EL_SCL;
                end
                S_EL_SCL: begin
                    if (w_shr > (2*VALUE_W)'(VAL_MAX)) begin
                        r_scl <= VAL_MAX;
                    end else if (w_shr < (2*VALUE_W)'(VAL_MIN)) begin
                        r_scl <= VAL_MIN;
                    end else begin
                        r_scl <= w_shr[VALUE_W-1:0];
                    end
                    r_state <= S_EL_WR;
                end
                S_EL_WR: begin
                    if (r_c == w_n) begin
                        r_state <= S_EL_ZERO;
                    end else begin
                        r_c     <= r_c + IW'(1);
                        r_state <= S_EL_RD0;
                    end
                end
                S_EL_ZERO: begin
                    if (r_i == w_n_m1) begin
                        r_i     <= '0;
                        r_c     <= '0;
                        r_zeros <= '0;
                        r_state <= S_TR_RD;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_EL_ROW;
                    end
                end
                S_TR_RD: r_state <= S_TR_CHK;
                S_TR_CHK: begin
                    if (r_c == w_n) begin
                        if ((w_zeros_new == {1'b0, w_n} + (IW+1)'(1)) ||
                            ((w_zeros_new == {1'b0, w_n}) && !w_zero)) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= '0;
                            r_out_st    <= w_zero ? ST_INFINITE : ST_NONE;
                            r_out_last  <= 1'b1;
                            r_state     <= S_OUT_WAIT;
                        end else if (r_i == w_n_m1) begin
                            r_c     <= '0;
                            r_state <= S_NM_RD;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_c     <= '0;
                            r_zeros <= '0;
                            r_state <= S_TR_RD;
                        end
                    end else begin
                        r_c     <= r_c + IW'(1);
                        r_zeros <= w_zeros_new;
                        r_state <= S_TR_RD;
                    end
                end
                S_NM_RD: r_state <= S_NM_DIV;
                S_NM_DIV: r_state <= S_NM_WAIT;
                S_NM_WAIT: begin
                    if (w_div_done) begin
                        if (r_c == w_n) begin
                            if (r_k == w_n_m1) begin
                                r_i     <= '0;
                                r_state <= S_OUT_RD;
                            end else begin
                                r_k     <= r_k + IW'(1);
                                r_state <= S_EL_PIV;
                            end
                        end else begin
                            r_c     <= r_c + IW'(1);
                            r_state <= S_NM_RD;
                        end
                    end
                end
                S_OUT_RD: r_state <= S_OUT_SET;
                S_OUT_SET: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= w_rd_data;
                    r_out_st    <= ST_UNIQUE;
                    r_out_last  <= (r_i == w_n_m1);
                    r_state     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/gjls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjls_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gjls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/gjls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjls_div
// Bit-serial fixed-point divider: (num << FRAC_BITS) / den, saturated.
// ----------------------------------------------------------------------------
module gjls_div
    import gjls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [VALUE_W-1:0] i_num,
    input  logic signed [VALUE_W-1:0] i_den,
    output logic                      o_done,
    output logic signed [VALUE_W-1:0] o_quot
);

    localparam int NW = VALUE_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_SAT} t_dstate;

    t_dstate                   r_state;
    logic [CW-1:0]             r_cnt;
    logic [NW-1:0]             r_q;
    logic [VALUE_W-1:0]        r_rem;
    logic [VALUE_W-1:0]        r_dmag;
    logic                      r_neg;
    logic                      r_done;
    logic signed [VALUE_W-1:0] r_quot;

    logic [VALUE_W-1:0] w_nmag;
    logic [VALUE_W:0]   w_rem_sh;
    logic               w_ge;
    logic [VALUE_W:0]   w_diff;
    logic               w_big_pos;
    logic               w_big_neg;

    assign w_nmag    = i_num[VALUE_W-1] ? VALUE_W'(-i_num) : VALUE_W'(i_num);
    assign w_rem_sh  = {r_rem, r_q[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_dmag});
    assign w_diff    = w_rem_sh - {1'b0, r_dmag};
    assign w_big_pos = |r_q[NW-1:VALUE_W-1];
    assign w_big_neg = (|r_q[NW-1:VALUE_W]) || (r_q[VALUE_W-1] && (|r_q[VALUE_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (i_den == '0) begin
                            r_done <= 1'b1;
                            if (i_num == '0) begin
                                r_quot <= '0;
                            end else if (i_num[VALUE_W-1]) begin
                                r_quot <= VAL_MIN;
                            end else begin
                                r_quot <= VAL_MAX;
                            end
                        end else begin
                            r_q     <= {w_nmag, {FRAC_BITS{1'b0}}};
                            r_rem   <= '0;
                            r_dmag  <= i_den[VALUE_W-1] ? VALUE_W'(-i_den) : VALUE_W'(i_den);
                            r_neg   <= i_num[VALUE_W-1] ^ i_den[VALUE_W-1];
                            r_cnt   <= CW'(NW);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= w_ge ? w_diff[VALUE_W-1:0] : w_rem_sh[VALUE_W-1:0];
                    r_q   <= {r_q[NW-2:0], w_ge};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= D_SAT;
                    end
                end
                D_SAT: begin
                    if (r_neg) begin
                        r_quot <= w_big_neg ? VAL_MIN : VALUE_W'(-r_q[VALUE_W-1:0]);
                    end else begin
                        r_quot <= w_big_pos ? VAL_MAX : VALUE_W'(r_q[VALUE_W-1:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/gjls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjls_checker
// Port-level checks of the solver core, bound into the core module.
// ----------------------------------------------------------------------------
`include "gauss_jordan_linear_solver_core_macros.svh"

module gjls_checker
    import gjls_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [VALUE_W-1:0]  m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser,
    input logic                m_axis_tlast
);

    `GJLS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `GJLS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `GJLS_ASSERT_IMP(a_status_word, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_UNIQUE), m_axis_tlast && (m_axis_tdata == '0))
    `GJLS_ASSERT_NXT(a_back_to_load, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready)

endmodule

bind gauss_jordan_linear_solver_core gjls_checker u_gjls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gauss_jordan_linear_solver_core. Coefficient words
// are streamed in at random pacing; a fixed-point Gauss-Jordan solver in the
// bench predicts every answer word, and a monitor compares value, status and
// tlast in order. Orders from the extremes up are used, plus back-pressure.
// ----------------------------------------------------------------------------
module tb
    import gjls_pkg::*;
;

    localparam int  MAX_N      = 8;
    localparam int  FRAC       = 16;
    localparam int  DEPTH      = MAX_N * (MAX_N + 1);
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  RAND_ITEMS = 16;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic               last;
    } t_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [ORDER_W-1:0]  i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    gauss_jordan_linear_solver_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // mirror of the block
    logic signed [31:0] mat [0:DEPTH-1];
    logic [ORDER_W-1:0] order_reg = ORDER_RESET;
    int                 load_pos = 0;

    t_answer answer_q[$];
    int      fails = 0;
    int      words_in = 0;
    int      answers_seen = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    int      hold_req = 0;
    int      stall_left = 0;

    function automatic int eff_order();
        int n;
        n = order_reg;
        if (n < 1) n = 1;
        if (n > MAX_N) n = MAX_N;
        return n;
    endfunction

    function automatic logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return VAL_MAX;
        if (v < -64'sd2147483648) return VAL_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat(p / (64'sd1 << FRAC));
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        if (b == 0) begin
            if (a > 0) return VAL_MAX;
            if (a < 0) return VAL_MIN;
            return 0;
        end
        return sat((longint'(a) * (64'sd1 << FRAC)) / longint'(b));
    endfunction

    function automatic int at(int n, int r, int c);
        return r * (n + 1) + c;
    endfunction

    function automatic int first_zero(int n);
        for (int i = 0; i < n; i++)
            if (mat[at(n, i, i)] == 0) return i;
        return n;
    endfunction

    function automatic void repair(int n, int k);
        logic signed [31:0] t;
        for (int j = 0; j < n; j++) begin
            if (mat[at(n, j, k)] != 0 && mat[at(n, k, j)] != 0) begin
                for (int c = 0; c <= n; c++) begin
                    t = mat[at(n, j, c)];
                    mat[at(n, j, c)] = mat[at(n, k, c)];
                    mat[at(n, k, c)] = t;
                end
                return;
            end
        end
    endfunction

    function automatic t_status row_status(int n);
        int zeros;
        for (int r = 0; r < n; r++) begin
            zeros = 0;
            for (int c = 0; c <= n; c++)
                if (mat[at(n, r, c)] == 0) zeros++;
            if (zeros == n + 1) return ST_INFINITE;
            if (zeros == n && mat[at(n, r, n)] != 0) return ST_NONE;
        end
        return ST_UNIQUE;
    endfunction

    function automatic void push_answer(logic [31:0] v, t_status st, logic l);
        t_answer a;
        a.value = v;
        a.status = st;
        a.last = l;
        answer_q.push_back(a);
    endfunction

    function automatic void solve_matrix(int n);
        int                 attempts;
        int                 z;
        t_status            st;
        logic signed [31:0] piv;
        logic signed [31:0] f;
        attempts = 0;
        z = first_zero(n);
        while (z != n) begin
            repair(n, z);
            z = first_zero(n);
            attempts++;
            if (attempts >= n) begin
                push_answer(0, ST_OVERDEF, 1'b1);
                return;
            end
        end
        for (int k = 0; k < n; k++) begin
            piv = mat[at(n, k, k)];
            for (int r = 0; r < n; r++) begin
                if (r == k) continue;
                f = fx_div(mat[at(n, r, k)], piv);
                for (int c = 0; c <= n; c++) begin
                    if (c == k) continue;
                    mat[at(n, r, c)] = sat(longint'(mat[at(n, r, c)]) -
                                           longint'(fx_mul(f, mat[at(n, k, c)])));
                end
                mat[at(n, r, k)] = 0;
            end
            st = row_status(n);
            if (st != ST_UNIQUE) begin
                push_answer(0, st, 1'b1);
                return;
            end
            piv = mat[at(n, k, k)];
            for (int c = 0; c <= n; c++)
                if (c != k) mat[at(n, k, c)] = fx_div(mat[at(n, k, c)], piv);
            mat[at(n, k, k)] = fx_div(piv, piv);
        end
        for (int i = 0; i < n; i++)
            push_answer(mat[at(n, i, n)], ST_UNIQUE, (i + 1 == n));
    endfunction

    function automatic void load_coeff(logic signed [31:0] v);
        int n;
        n = eff_order();
        if (load_pos >= n * (n + 1)) load_pos = 0;
        mat[load_pos] = v;
        load_pos++;
        if (load_pos >= n * (n + 1)) begin
            solve_matrix(n);
            load_pos = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sink pacing
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
                $error("unexpected word: value %h status %0d last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fails++;
            end else begin
                a = answer_q.pop_front();
                if (m_axis_tdata !== a.value) begin
                    $error("value: expected %h, got %h", a.value, m_axis_tdata);
                    fails++;
                end
                if (m_axis_tuser !== a.status) begin
                    $error("status: expected %0d, got %0d", a.status, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tlast !== a.last) begin
                    $error("last: expected %0b, got %0b", a.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    task automatic send_coeff(logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        load_coeff(v);
        words_in++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_order(logic [ORDER_W-1:0] v);
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
        order_reg = v;
        load_pos = 0;
    endtask

    function automatic logic [31:0] small_fx(int lo, int hi);
        return ($urandom_range(0, hi - lo) + lo) * 65536 + $urandom_range(0, 65535);
    endfunction

    task automatic send_random_matrix();
        logic [31:0] m [0:DEPTH-1];
        int          n;
        int          kind;
        n = eff_order();
        kind = $urandom_range(0, 9);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++) begin
                if (kind == 0)
                    m[at(n, r, c)] = $urandom;
                else if (kind <= 2 && $urandom_range(0, 1))
                    m[at(n, r, c)] = 0;
                else if (r == c)
                    m[at(n, r, c)] = small_fx(4 * n, 4 * n + 8) *
                                     ($urandom_range(0, 1) ? 1 : -1);
                else
                    m[at(n, r, c)] = small_fx(-8, 8);
            end
        if (kind == 3 && n > 1)
            for (int c = 0; c <= n; c++) m[at(n, 1, c)] = m[at(n, 0, c)];
        if (kind == 4)
            m[at(n, 0, 0)] = 0;
        for (int i = 0; i < n * (n + 1); i++) send_coeff(m[i]);
    endtask

    task automatic test_reset_order();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c <= 4; c++)
                send_coeff(r == c ? 32'h0002_0000 : (c == 4 ? r * 32'h0001_8000 : 0));
    endtask

    task automatic test_directed();
        calm = 1'b1;
        set_order(ORDER_W'(1));
        send_coeff(0);            send_coeff(32'h0005_0000);  // no pivot
        send_coeff(VAL_MAX);      send_coeff(VAL_MIN);
        send_coeff(VAL_MIN);      send_coeff(VAL_MAX);
        calm = 1'b0;
        set_order(ORDER_W'(2));
        // zero pivot fixed by a swap
        send_coeff(0); send_coeff(32'h0001_0000); send_coeff(32'h0003_0000);
        send_coeff(32'h0001_0000); send_coeff(0); send_coeff(32'h0004_0000);
        // identical rows
        send_coeff(32'h0001_0000); send_coeff(32'h0001_0000); send_coeff(32'h0002_0000);
        send_coeff(32'h0001_0000); send_coeff(32'h0001_0000); send_coeff(32'h0002_0000);
        // inconsistent rows
        send_coeff(32'h0001_0000); send_coeff(32'h0001_0000); send_coeff(32'h0002_0000);
        send_coeff(32'h0001_0000); send_coeff(32'h0001_0000); send_coeff(32'h0003_0000);
    endtask

    task automatic test_order_limits();
        set_order(ORDER_W'(0));
        send_random_matrix();
        set_order(ORDER_W'(15));
        send_random_matrix();
    endtask

    task automatic test_backpressure();
        set_order(ORDER_W'(1));
        hold_req = 400;
        for (int i = 0; i < 4; i++) send_random_matrix();
    endtask

    task automatic test_random();
        int start_in;
        int r;
        start_in = words_in;
        while (words_in - start_in < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 85) set_order(ORDER_W'($urandom_range(1, 3)));
            else        set_order(ORDER_W'(4));
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 2)) send_random_matrix();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_order();
        test_directed();
        test_order_limits();
        test_backpressure();
        test_random();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gjls_pkg.sv
rtl/gjls_ram.sv
rtl/gjls_div.sv
rtl/gauss_jordan_linear_solver_core.sv
rtl/gjls_checker.sv
tb/tb.sv
